// File: rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int NODE_BITS   = 16;
   localparam int COST_BITS   = 32;
   localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

   // opcode values
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                 opcode;
      logic [NODE_BITS-1:0] node_dest;
      logic [NODE_BITS-1:0] node_via;
      logic [COST_BITS-1:0] new_cost;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0] best_cost;
      logic [NODE_BITS-1:0] best_hop;
      logic                 route_found;
      logic [COST_BITS-1:0] direct_cost;
      logic                 direct_found;
      logic                 update_dropped;
   } rsp_type;

   // one table row as stored in memory
   typedef struct packed {
      logic [NODE_BITS-1:0] dest;
      logic [NODE_BITS-1:0] hop;
      logic [COST_BITS-1:0] cost;
   } row_type;

endpackage

// File: rtl/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route table of (destination, next hop, cost) rows kept in insertion order,
// with update/insert and best-route query over a single row memory.
// ----------------------------------------------------------------------------
//
//   channel | ports                         | moves
//   --------+-------------------------------+-------------------------------
//   request | req_valid / req_ready / req_data | update or query transaction
//   result  | rsp_valid / rsp_ready / rsp_data | one result per transaction
//
// Timing: a request is taken in the idle state; the scan then reads the used
// rows in order, and the result is loaded into the output register before the
// next request is taken, so one transaction is handled at a time. An update
// that hits a row ends early, right after that row is read. The scan reads
// one row per cycle from the row memory.
// Reset clears the row count and control state; row contents stay undefined
// and are never read above the row count, so no clearing pass is needed.
// The result sits in an output register, so a stalled rsp_ready does not
// stop the next request from being accepted; it only holds the following
// result until the register frees up.
// ----------------------------------------------------------------------------
module distance_vector_route_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dvrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dvrt_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // row memory, one row per entry, synchronous read
   dvrt_pkg::row_type mem [dvrt_pkg::TABLE_DEPTH];

   state_type                        state_ff, state_in;
   dvrt_pkg::req_type                req_ff, req_in;
   dvrt_pkg::rsp_type                res_ff, res_in;
   dvrt_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dvrt_pkg::CNT_BITS-1:0]    used_ff, used_in;
   logic [dvrt_pkg::CNT_BITS-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [dvrt_pkg::ADDR_BITS-1:0]   rd_idx_ff, rd_idx_in;
   dvrt_pkg::row_type                rd_row_ff;

   logic                             rd_en;
   logic [dvrt_pkg::ADDR_BITS-1:0]   rd_addr;
   logic                             wr_en;
   logic [dvrt_pkg::ADDR_BITS-1:0]   wr_addr;
   dvrt_pkg::row_type                wr_data;
   logic                             issue;
   logic                             stop;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      used_in      = used_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = issue_cnt_ff[dvrt_pkg::ADDR_BITS-1:0];
      rd_en        = 1'b0;
      rd_addr      = issue_cnt_ff[dvrt_pkg::ADDR_BITS-1:0];
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_data      = rd_row_ff;
      issue        = (issue_cnt_ff != used_ff);
      stop         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               res_in       = '0;
               issue_cnt_in = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // consume the row read last cycle
            if (rd_vld_ff) begin
               if (req_ff.opcode == dvrt_pkg::OP_UPDATE) begin
                  if (rd_row_ff.hop == req_ff.node_via &&
                      rd_row_ff.dest == req_ff.node_dest) begin
                     wr_en        = 1'b1;
                     wr_addr      = rd_idx_ff;
                     wr_data      = rd_row_ff;
                     wr_data.cost = req_ff.new_cost;
                     stop         = 1'b1;
                  end
               end else if (rd_row_ff.dest == req_ff.node_dest) begin
                  // strict less-than keeps the earliest minimum row
                  if (!res_ff.route_found || rd_row_ff.cost < res_ff.best_cost) begin
                     res_in.best_cost   = rd_row_ff.cost;
                     res_in.best_hop    = rd_row_ff.hop;
                     res_in.route_found = 1'b1;
                  end
                  if (rd_row_ff.hop == req_ff.node_dest) begin
                     res_in.direct_cost  = rd_row_ff.cost;
                     res_in.direct_found = 1'b1;
                  end
               end
            end

            // all rows seen: an update that missed appends or drops
            if (!stop && !issue && !rd_vld_ff) begin
               stop = 1'b1;
               if (req_ff.opcode == dvrt_pkg::OP_UPDATE) begin
                  if (used_ff != dvrt_pkg::CNT_BITS'(dvrt_pkg::TABLE_DEPTH)) begin
                     wr_en        = 1'b1;
                     wr_addr      = used_ff[dvrt_pkg::ADDR_BITS-1:0];
                     wr_data.dest = req_ff.node_dest;
                     wr_data.hop  = req_ff.node_via;
                     wr_data.cost = req_ff.new_cost;
                     used_in      = used_ff + dvrt_pkg::CNT_BITS'(1);
                  end else begin
                     res_in.update_dropped = 1'b1;
                  end
               end
            end

            if (issue && !stop) begin
               rd_en        = 1'b1;
               rd_vld_in    = 1'b1;
               issue_cnt_in = issue_cnt_ff + dvrt_pkg::CNT_BITS'(1);
            end

            if (stop) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         rd_vld_ff    <= rd_vld_in;
      end
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      issue_cnt_ff <= issue_cnt_in;
      rd_idx_ff    <= rd_idx_in;
   end

   // row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/dvrt_checker.sv
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks for the route table, bound to the top level.
// ----------------------------------------------------------------------------
module dvrt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input dvrt_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dvrt_pkg::rsp_type rsp_data
);

   // transactions accepted but not yet answered
   logic [1:0] pend_ff, pend_in;
   logic       in_acc;
   logic       out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (in_acc && !out_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (!in_acc && out_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a stalled transaction holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // no result without an accepted request, at most two in flight
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || pend_ff != 2'd0) && pend_ff != 2'd3)
      else $error("result count does not match requests");

   // a drop flag only comes with an empty query part
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.update_dropped |->
         !rsp_data.route_found && !rsp_data.direct_found)
      else $error("dropped update with query data");

   // not-found fields read as zero
   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.route_found || (rsp_data.best_cost == '0 && rsp_data.best_hop == '0)) &&
         (rsp_data.direct_found || rsp_data.direct_cost == '0))
      else $error("nonzero field without found flag");

   // a direct link is itself a route
   a_direct_route: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.direct_found |-> rsp_data.route_found)
      else $error("direct link without route");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distance-vector route table. It drives update
// and query transactions, keeps a shadow copy of the table to predict each
// result, and checks every result field by field in order.
// ----------------------------------------------------------------------------
module tb;

   // A correct run never goes this long without a transaction on either side.
   // The longest is a full-table scan plus random gaps and stalls.
   localparam int QUIET_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 80;    // a little over one full-table scan
   localparam int RANDOM_ITEMS = 885;
   localparam int POOL_SIZE    = 12;

   // -------------------------------------------------------------------------
   // Scoreboard: a shadow route table that predicts each result, and an
   // in-order queue of those predictions.
   // -------------------------------------------------------------------------
   class route_table_scoreboard;
      logic [dvrt_pkg::NODE_BITS-1:0] row_dest [dvrt_pkg::TABLE_DEPTH];
      logic [dvrt_pkg::NODE_BITS-1:0] row_hop  [dvrt_pkg::TABLE_DEPTH];
      logic [dvrt_pkg::COST_BITS-1:0] row_cost [dvrt_pkg::TABLE_DEPTH];
      int unsigned                    row_count;
      dvrt_pkg::rsp_type              expected_rsp [$];
      int unsigned                    mismatches;
      int unsigned                    results_seen;

      function new();
         row_count    = 0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // Apply an accepted transaction to the shadow table and queue its result.
      function void note_request(input dvrt_pkg::req_type r);
         dvrt_pkg::rsp_type want;
         bit                hit;
         want = '0;
         hit  = 1'b0;
         if (r.opcode == dvrt_pkg::OP_UPDATE) begin
            // (hop, dest) pairs are unique: overwrite the match, else append, or drop when full
            for (int k = 0; k < row_count; k++) begin
               if (!hit && row_hop[k] == r.node_via && row_dest[k] == r.node_dest) begin
                  row_cost[k] = r.new_cost;
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               if (row_count < dvrt_pkg::TABLE_DEPTH) begin
                  row_dest[row_count] = r.node_dest;
                  row_hop[row_count]  = r.node_via;
                  row_cost[row_count] = r.new_cost;
                  row_count++;
               end else begin
                  want.update_dropped = 1'b1;
               end
            end
         end else begin
            // strict less-than keeps the earliest row on a tie
            for (int k = 0; k < row_count; k++) begin
               if (row_dest[k] == r.node_dest) begin
                  if (!want.route_found || row_cost[k] < want.best_cost) begin
                     want.best_cost   = row_cost[k];
                     want.best_hop    = row_hop[k];
                     want.route_found = 1'b1;
                  end
                  if (row_hop[k] == r.node_dest) begin
                     want.direct_cost  = row_cost[k];
                     want.direct_found = 1'b1;
                  end
               end
            end
         end
         expected_rsp = {expected_rsp, want};
      endfunction

      function string field_diff(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
         if (got !== want)
            return $sformatf(" %s got %0h exp %0h", name, got, want);
         return "";
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("[%0t] result %0d mismatch:%s", $time, results_seen, what);
      endtask

      task check_result(input dvrt_pkg::rsp_type got);
         dvrt_pkg::rsp_type want;
         string             diffs;
         results_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch(" result with no transaction outstanding");
         end else begin
            want  = expected_rsp.pop_front();
            diffs = {field_diff("best_cost", 64'(got.best_cost), 64'(want.best_cost)),
                     field_diff("best_hop", 64'(got.best_hop), 64'(want.best_hop)),
                     field_diff("route_found", 64'(got.route_found),
                                64'(want.route_found)),
                     field_diff("direct_cost", 64'(got.direct_cost),
                                64'(want.direct_cost)),
                     field_diff("direct_found", 64'(got.direct_found),
                                64'(want.direct_found)),
                     field_diff("update_dropped", 64'(got.update_dropped),
                                64'(want.update_dropped))};
            if (diffs != "")
               report_mismatch(diffs);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dvrt_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dvrt_pkg::rsp_type rsp_data;

   // While set, neither side inserts gaps or stalls.
   bit      no_gap = 1'b0;
   int unsigned quiet_cycles = 0;

   logic [dvrt_pkg::NODE_BITS-1:0] node_pool [POOL_SIZE];
   route_table_scoreboard book;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   distance_vector_route_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Result side: ready changes at the falling edge, stalling about 16% of
   // the time; results are taken at the rising edge. The result register
   // lets a new request in while a stall holds the previous result, so
   // stalls land on every phase of the scan.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= no_gap ? 1'b1 : ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result(rsp_data);
   end

   // Watchdog: too many cycles with no transaction on either side means
   // the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side. Called at a falling edge; returns at the falling edge
   // after the transaction is taken, so valid stays up between back-to-back
   // transactions without being dropped and raised in one step.
   // -------------------------------------------------------------------------
   task send_request(input dvrt_pkg::req_type r);
      while (!no_gap && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!req_ready);
      book.note_request(r);
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding result has come back.
   task drain_results();
      req_valid <= 1'b0;
      while (book.pending() != 0)
         @(negedge clock);
   endtask

   function dvrt_pkg::req_type make_req(input logic op,
                                        input logic [dvrt_pkg::NODE_BITS-1:0] dest,
                                        input logic [dvrt_pkg::NODE_BITS-1:0] via,
                                        input logic [dvrt_pkg::COST_BITS-1:0] cost);
      dvrt_pkg::req_type r;
      r.opcode    = op;
      r.node_dest = dest;
      r.node_via  = via;
      r.new_cost  = cost;
      return r;
   endfunction

   // Mostly pool nodes so rows collide, hit and tie; now and then a fully
   // random node, which appends a fresh row or misses on a query.
   function logic [dvrt_pkg::NODE_BITS-1:0] pick_node();
      if ($urandom_range(0, 9) == 0)
         return dvrt_pkg::NODE_BITS'($urandom);
      return node_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Small whole-number costs make ties common; extremes and full-range
   // values cover the rest.
   function logic [dvrt_pkg::COST_BITS-1:0] pick_cost();
      case ($urandom_range(0, 3))
         0: return {16'($urandom_range(0, 3)), 16'h0000};
         1: return $urandom_range(0, 1) ? {dvrt_pkg::COST_BITS{1'b1}} : '0;
         default: return $urandom;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Directed part: empty table, extremes, overwrite, ties, direct links.
   // -------------------------------------------------------------------------
   task run_directed();
      // queries on the empty table, ignored fields at both extremes
      send_request(make_req(dvrt_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0000_0000));
      send_request(make_req(dvrt_pkg::OP_QUERY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      // destination 1: several hops, a direct link, a tie at cost zero
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'h0001, 16'h0002, 32'h0000_0000));
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'h0001, 16'h0001, 32'hFFFF_FFFF));
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'h0001, 16'h0003, 32'h0001_0000));
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'h0001, 16'h0004, 32'h0000_0000));
      send_request(make_req(dvrt_pkg::OP_QUERY, 16'h0001, 16'hAAAA, 32'h5555_5555));
      // overwrite the first row; the tie now falls to the later zero row
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'h0001, 16'h0002, 32'h0002_8000));
      send_request(make_req(dvrt_pkg::OP_QUERY, 16'h0001, 16'h5555, 32'hAAAA_AAAA));
      // overwrite the direct link down to zero: it becomes the earliest best
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'h0001, 16'h0001, 32'h0000_0000));
      send_request(make_req(dvrt_pkg::OP_QUERY, 16'h0001, 16'h0000, 32'h0000_0000));
      // all-ones destination with all-ones and all-zeros hops
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_request(make_req(dvrt_pkg::OP_UPDATE, 16'hFFFF, 16'h0000, 32'h0000_0000));
      send_request(make_req(dvrt_pkg::OP_QUERY, 16'hFFFF, 16'h0000, 32'h0000_0000));
      // a destination that only ever appeared as a hop
      send_request(make_req(dvrt_pkg::OP_QUERY, 16'h0002, 16'hFFFF, 32'hFFFF_FFFF));
   endtask

   // -------------------------------------------------------------------------
   // Random part. Early on updates dominate so the table fills; once it is
   // full, new pairs are dropped while matching pairs still overwrite.
   // -------------------------------------------------------------------------
   task run_random();
      dvrt_pkg::req_type r;
      int                update_pct;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_gap     = (n >= 400 && n < 550);
         update_pct = (n < 300) ? 60 : 40;
         r.opcode    = ($urandom_range(0, 99) < update_pct) ? dvrt_pkg::OP_UPDATE
                                                            : dvrt_pkg::OP_QUERY;
         r.node_dest = pick_node();
         r.node_via  = ($urandom_range(0, 4) == 0) ? r.node_dest : pick_node();
         r.new_cost  = pick_cost();
         send_request(r);
         if (n == 150 || n == 600)
            drain_results();
      end
      no_gap = 1'b0;
   endtask

   initial begin
      book = new();
      node_pool[0] = '0;
      node_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         node_pool[i] = dvrt_pkg::NODE_BITS'($urandom);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      drain_results();
      run_random();
      drain_results();
      // let anything stray come out before the verdict
      repeat (TAIL_CYCLES) @(negedge clock);

      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
